/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL; each check reports through $error.
// Relies on signals named clk and rst_n in the module that uses the macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MDA_ASSERT(lbl, prop, msg)
`define MDA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/mda_pkg.sv */
// Shared types and constants of the morph delta accumulator.
// No dependencies; used by every module of the block.
package mda_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int LIMIT_W      = 17;
  localparam int LANES        = 6;
  localparam int VCNT_W       = 13;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC
  } state_t;

  typedef struct packed {
    action_t            action;
    logic [15:0]        vert_index;
    logic signed [15:0] weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
  } request_t;

  typedef struct packed {
    logic               status;
    logic [15:0]        out_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_norm_x;
    logic signed [31:0] out_norm_y;
    logic signed [31:0] out_norm_z;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic sel_load;
    logic sel_add;
  } lane_ctrl_t;

endpackage

/* hw/rtl/morph_delta_accumulator_core.sv */
// Top level of the morph delta accumulator: request control, six lanes, merge.
// Depends on mda_pkg, mda_lane, mda_merge and assert_macros.svh.
//
//   channel   ports                     handshake
//   request   start, busy, in_req       taken when start is high and busy low
//   result    out_valid, out_res        one-cycle strobe, cannot be held off
//   config    cfg_we, cfg_wdata         vertex count written when cfg_we high
//
// After the edge that accepts a request, the READ state reads the lane stores
// and registers the delta times weight products; the ACC state adds,
// saturates, writes back and loads the merge register, whose output is the
// result strobe. busy stays high through READ and ACC; a new request may be
// taken in the cycle the strobe shows.
// Reset clears control state and the vertex count; the stores stay undefined
// until loaded, and the receiver never stalls the block.
`include "assert_macros.svh"

module morph_delta_accumulator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  mda_pkg::request_t             in_req,
  output logic                          out_valid,
  output mda_pkg::result_t              out_res,
  input  logic                          cfg_we,
  input  logic [mda_pkg::VCNT_W-1:0]    cfg_wdata
);

  mda_pkg::state_t   state_r;
  mda_pkg::state_t   state_nxt;
  mda_pkg::request_t req_r;
  logic              in_range_r;
  logic              in_range_nxt;
  logic [mda_pkg::VCNT_W-1:0]  vcount_r;
  logic [mda_pkg::LIMIT_W-1:0] limit;
  logic                accept;
  logic                capture;
  logic                is_load;
  logic                is_add;
  mda_pkg::lane_ctrl_t lane_ctrl;
  logic signed [31:0]  delta [mda_pkg::LANES];
  logic signed [31:0]  lane_val [mda_pkg::LANES];

  // Configuration register: no wait, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  // Clamp the vertex count to the store depth before the range check
  assign limit = (mda_pkg::LIMIT_W'(vcount_r) > mda_pkg::LIMIT_W'(mda_pkg::MAX_VERTICES))
               ? mda_pkg::LIMIT_W'(mda_pkg::MAX_VERTICES)
               : mda_pkg::LIMIT_W'(vcount_r);
  assign in_range_nxt = mda_pkg::LIMIT_W'(in_req.vert_index) < limit;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the request and its range verdict for the whole pass
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_req;
      in_range_r <= in_range_nxt;
    end
  end

  // Decode the action; the unused code reads like a read request
  always_comb begin
    unique case (req_r.action)
      mda_pkg::ACT_LOAD: begin
        is_load = 1'b1;
        is_add  = 1'b0;
      end
      mda_pkg::ACT_ADD: begin
        is_load = 1'b0;
        is_add  = 1'b1;
      end
      default: begin
        is_load = 1'b0;
        is_add  = 1'b0;
      end
    endcase
  end

  // Sequencer: read and multiply, then accumulate and write back
  always_comb begin
    state_nxt          = state_r;
    busy               = 1'b1;
    capture            = 1'b0;
    lane_ctrl.rd_en    = 1'b0;
    lane_ctrl.wr_en    = 1'b0;
    lane_ctrl.sel_load = is_load;
    lane_ctrl.sel_add  = is_add;
    unique case (state_r)
      mda_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt = mda_pkg::ST_READ;
        end
      end
      mda_pkg::ST_READ: begin
        lane_ctrl.rd_en = 1'b1;
        state_nxt       = mda_pkg::ST_ACC;
      end
      mda_pkg::ST_ACC: begin
        // drop the write for an index at or beyond the vertex count
        lane_ctrl.wr_en = in_range_r && (is_load || is_add);
        capture         = 1'b1;
        state_nxt       = mda_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mda_pkg::ST_IDLE;
      end
    endcase
  end

  assign delta[0] = req_r.pos_x;
  assign delta[1] = req_r.pos_y;
  assign delta[2] = req_r.pos_z;
  assign delta[3] = req_r.norm_x;
  assign delta[4] = req_r.norm_y;
  assign delta[5] = req_r.norm_z;

  // One lane per vertex component, all sharing address and weight
  for (genvar g = 0; g < mda_pkg::LANES; g++) begin : g_lane
    mda_lane u_lane (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .addr    (req_r.vert_index[mda_pkg::VIDX_W-1:0]),
      .delta   (delta[g]),
      .weight  (req_r.weight),
      .new_val (lane_val[g])
    );
  end

  mda_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .capture   (capture),
    .status    (!in_range_r),
    .index     (req_r.vert_index),
    .lane_val  (lane_val),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  `MDA_ASSERT(a_strobe_idle, out_valid |-> !busy, "result strobe while a request is in flight")
  `MDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after acceptance")
  `MDA_ASSERT_NEXT(a_acc_strobe, state_r == mda_pkg::ST_ACC, out_valid, "accumulate without result")
  `MDA_ASSERT(a_oor_zero, (out_valid && out_res.status) |-> (out_res.out_pos_x == 0 &&
    out_res.out_norm_z == 0), "ignored request returned values")

endmodule

/* hw/rtl/mda_lane.sv */
// One component lane: vertex word store, weight multiply and saturating add.
// Depends on mda_pkg.
module mda_lane (
  input  logic                        clk,
  input  mda_pkg::lane_ctrl_t         ctrl,
  input  logic [mda_pkg::VIDX_W-1:0]  addr,
  input  logic signed [31:0]          delta,
  input  logic signed [15:0]          weight,
  output logic signed [31:0]          new_val
);

  logic signed [31:0] mem [mda_pkg::MAX_VERTICES];
  logic signed [31:0] rd_r;
  logic signed [47:0] prod_r;
  logic signed [47:0] prod_nxt;
  logic signed [35:0] scaled;
  logic signed [36:0] sum;
  logic signed [31:0] sat_val;

  assign prod_nxt = delta * weight;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr] <= new_val;
    end
    if (ctrl.rd_en) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      prod_r <= prod_nxt;
    end
  end

  // floor shift: drop the low twelve bits of the product
  assign scaled = prod_r[47:12];
  assign sum    = 37'(rd_r) + 37'(scaled);

  always_comb begin
    if ((~|sum[36:31]) || (&sum[36:31])) begin
      sat_val = sum[31:0];
    end else begin
      sat_val = sum[36] ? mda_pkg::VAL_MIN : mda_pkg::VAL_MAX;
    end
  end

  always_comb begin
    if (ctrl.sel_load) begin
      new_val = delta;
    end else if (ctrl.sel_add) begin
      new_val = sat_val;
    end else begin
      new_val = rd_r;
    end
  end

endmodule

/* hw/rtl/mda_merge.sv */
// Merge stage: gathers the six lane values into one registered result strobe.
// Depends on mda_pkg.
module mda_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                capture,
  input  logic                status,
  input  logic [15:0]         index,
  input  logic signed [31:0]  lane_val [mda_pkg::LANES],
  output logic                out_valid,
  output mda_pkg::result_t    out_res
);

  logic             out_valid_r;
  mda_pkg::result_t res_r;
  mda_pkg::result_t res_nxt;

  always_comb begin
    res_nxt.status    = status;
    res_nxt.out_index = index;
    if (status) begin
      res_nxt.out_pos_x  = '0;
      res_nxt.out_pos_y  = '0;
      res_nxt.out_pos_z  = '0;
      res_nxt.out_norm_x = '0;
      res_nxt.out_norm_y = '0;
      res_nxt.out_norm_z = '0;
    end else begin
      res_nxt.out_pos_x  = lane_val[0];
      res_nxt.out_pos_y  = lane_val[1];
      res_nxt.out_pos_z  = lane_val[2];
      res_nxt.out_norm_x = lane_val[3];
      res_nxt.out_norm_y = lane_val[4];
      res_nxt.out_norm_z = lane_val[5];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= capture;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

/* dv/mda_vertex_checker.sv */
// Result checker for the morph delta accumulator: predicts each vertex and compares.
// Depends on mda_pkg; instantiated beside the block by tb_morph_delta_accumulator_core.
`timescale 1ns / 100ps

module mda_vertex_checker
  import mda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  request_t          in_req,
  input  logic              out_valid,
  input  result_t           out_res,
  input  logic              cfg_we,
  input  logic [VCNT_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                outstanding
);

  // Lanes 0..2 hold the position, 3..5 the normal.
  logic signed [31:0] vertex_words [MAX_VERTICES][LANES];
  logic [VCNT_W-1:0]  vcount;
  result_t            expected_vertices [$];
  result_t            want;

  // Apply one request to the vertex copy and return the vertex as it then stands.
  function automatic result_t morph_vertex(request_t r);
    logic signed [31:0] lane_in [LANES];
    result_t            res;
    longint             acc;
    int unsigned        limit;
    lane_in[0] = r.pos_x;
    lane_in[1] = r.pos_y;
    lane_in[2] = r.pos_z;
    lane_in[3] = r.norm_x;
    lane_in[4] = r.norm_y;
    lane_in[5] = r.norm_z;
    limit = (vcount < MAX_VERTICES) ? vcount : MAX_VERTICES;
    res = '0;
    res.out_index = r.vert_index;
    if (r.vert_index >= limit) begin
      res.status = 1'b1;
      return res;
    end
    for (int k = 0; k < LANES; k++) begin
      case (r.action)
        ACT_LOAD: vertex_words[r.vert_index][k] = lane_in[k];
        ACT_ADD: begin
          // floor shift of the exact product, then clamp the sum
          acc = longint'(vertex_words[r.vert_index][k])
              + ((longint'(lane_in[k]) * longint'(r.weight)) >>> 12);
          if (acc > VAL_MAX) acc = VAL_MAX;
          if (acc < VAL_MIN) acc = VAL_MIN;
          vertex_words[r.vert_index][k] = acc[31:0];
        end
        default: ;
      endcase
    end
    res.out_pos_x  = vertex_words[r.vert_index][0];
    res.out_pos_y  = vertex_words[r.vert_index][1];
    res.out_pos_z  = vertex_words[r.vert_index][2];
    res.out_norm_x = vertex_words[r.vert_index][3];
    res.out_norm_y = vertex_words[r.vert_index][4];
    res.out_norm_z = vertex_words[r.vert_index][5];
    return res;
  endfunction

  function automatic void compare_field(string field, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, got_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      vcount = '0;
      expected_vertices.delete();
    end else begin
      if (out_valid) begin
        if (expected_vertices.size() == 0) begin
          $error("result for vertex %0d with no request waiting", out_res.out_index);
          fail_count++;
        end else begin
          want = expected_vertices.pop_front();
          compare_field("status",     want.status,     out_res.status);
          compare_field("out_index",  want.out_index,  out_res.out_index);
          compare_field("out_pos_x",  want.out_pos_x,  out_res.out_pos_x);
          compare_field("out_pos_y",  want.out_pos_y,  out_res.out_pos_y);
          compare_field("out_pos_z",  want.out_pos_z,  out_res.out_pos_z);
          compare_field("out_norm_x", want.out_norm_x, out_res.out_norm_x);
          compare_field("out_norm_y", want.out_norm_y, out_res.out_norm_y);
          compare_field("out_norm_z", want.out_norm_z, out_res.out_norm_z);
        end
      end
      if (start && !busy)
        expected_vertices.push_back(morph_vertex(in_req));
      if (cfg_we)
        vcount = cfg_wdata;
    end
    outstanding = expected_vertices.size();
  end

endmodule

/* dv/tb_morph_delta_accumulator_core.sv */
// Testbench top of the morph delta accumulator: clock, reset, requests, verdict.
// Depends on mda_pkg, morph_delta_accumulator_core and mda_vertex_checker.
`timescale 1ns / 100ps

module tb_morph_delta_accumulator_core;
  import mda_pkg::*;

  // The action field carries a fourth code that the block treats as a read.
  localparam action_t ACT_SPARE = action_t'(2'd3);
  localparam int      PHASE_LEN = 210;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  request_t          in_req;
  logic              out_valid;
  result_t           out_res;
  logic              cfg_we;
  logic [VCNT_W-1:0] cfg_wdata;
  int                fail_count;
  int                outstanding;

  // Stimulus-side view of the block: which vertices hold a rest value, and
  // the index limit that the vertex count currently gives.
  bit                loaded [MAX_VERTICES];
  int unsigned       cur_limit;

  morph_delta_accumulator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mda_vertex_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_res     (out_res),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case a result never arrives or busy sticks high.
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Issue one request: hold start low for a random gap, then present the
  // request and advance until the block takes it. Entered and left on a
  // falling edge; start stays high afterwards so that a zero gap gives
  // back-to-back requests without dropping start in between.
  task automatic issue_request(request_t r);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req <= r;
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // a load below the limit is the only thing that makes a vertex usable
    if (r.action == ACT_LOAD && r.vert_index < cur_limit)
      loaded[r.vert_index] = 1'b1;
    @(negedge clk);
  endtask

  // Drop start and hold until every expected result has come back; nothing
  // is in flight after the last strobe, the extra cycles are only margin.
  task automatic drain_requests();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Change the vertex count only with the block idle.
  task automatic set_vertex_count(int unsigned count);
    drain_requests();
    cfg_wdata <= count[VCNT_W-1:0];
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_limit = (count < MAX_VERTICES) ? count : MAX_VERTICES;
  endtask

  // Directed request with the same value in all six lanes.
  function automatic request_t vertex_request(action_t act, logic [15:0] idx,
                                              logic signed [15:0] w,
                                              logic signed [31:0] v);
    request_t r;
    r.action     = act;
    r.vert_index = idx;
    r.weight     = w;
    r.pos_x      = v;
    r.pos_y      = v;
    r.pos_z      = v;
    r.norm_x     = v;
    r.norm_y     = v;
    r.norm_z     = v;
    return r;
  endfunction

  // Mostly modest values so that sums accumulate over many adds; some full
  // range words and rails to drive saturation and toggle every bit.
  function automatic logic signed [31:0] lane_value();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      default: return int'($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  function automatic logic signed [15:0] weight_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return $urandom_range(0, 1) ? 16'sh1000 : -16'sh1000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random request: most go to in-range vertices, half of those to a small hot
  // set so that adds pile up on loaded data; the rest go to the limit or above.
  // An in-range vertex with no rest value yet is always loaded first.
  function automatic request_t random_request();
    request_t    r;
    int unsigned hot;
    int unsigned pick;
    hot = (cur_limit < 8) ? cur_limit : 8;
    if (cur_limit > 0 && $urandom_range(0, 99) < 85)
      r.vert_index = $urandom_range(0, 1) ? 16'($urandom_range(0, hot - 1))
                                          : 16'($urandom_range(0, cur_limit - 1));
    else
      r.vert_index = 16'($urandom_range(cur_limit, 65535));
    pick = $urandom_range(0, 19);
    if (pick < 4)       r.action = ACT_LOAD;
    else if (pick < 15) r.action = ACT_ADD;
    else if (pick < 19) r.action = ACT_READ;
    else                r.action = ACT_SPARE;
    if (r.vert_index < cur_limit && !loaded[r.vert_index])
      r.action = ACT_LOAD;
    r.weight = weight_value();
    r.pos_x  = lane_value();
    r.pos_y  = lane_value();
    r.pos_z  = lane_value();
    r.norm_x = lane_value();
    r.norm_y = lane_value();
    r.norm_z = lane_value();
    return r;
  endfunction

  initial begin
    int unsigned phase_counts [6];
    phase_counts = '{4096, 16, 8191, 1, 2500, 4096};
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    cur_limit = 0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // the vertex count resets to zero: everything is out of range
    issue_request(vertex_request(ACT_LOAD, 16'd0, 16'sh1000, 32'sh0001_0000));
    issue_request(vertex_request(ACT_READ, 16'd0, 16'sh0000, 32'sh0000_0000));

    set_vertex_count(4096);
    issue_request(vertex_request(ACT_LOAD, 16'd0,    16'sh0000, VAL_MAX));
    issue_request(vertex_request(ACT_LOAD, 16'd4095, 16'sh0000, VAL_MIN));
    issue_request(vertex_request(ACT_LOAD, 16'd1,    16'sh0000, 32'sh0000_0000));
    issue_request(vertex_request(ACT_READ, 16'd0,    16'sh0000, 32'sh0000_0000));
    // saturate at both rails
    issue_request(vertex_request(ACT_ADD, 16'd0,    16'sh7fff, VAL_MAX));
    issue_request(vertex_request(ACT_ADD, 16'd4095, 16'sh7fff, VAL_MIN));
    // floor rounding of a tiny negative product
    issue_request(vertex_request(ACT_ADD, 16'd1, 16'sh0001, -32'sd1));
    // most negative weight times most negative delta
    issue_request(vertex_request(ACT_ADD, 16'd1, 16'sh8000, VAL_MIN));
    // zero weight leaves the vertex alone
    issue_request(vertex_request(ACT_ADD, 16'd0, 16'sh0000, 32'sh1234_5678));
    issue_request(vertex_request(ACT_ADD, 16'd4095, 16'sh8000, VAL_MAX));
    issue_request(vertex_request(ACT_ADD, 16'd1, 16'sh1000, -32'sd5));
    issue_request(vertex_request(ACT_SPARE, 16'd1, 16'sh7fff, VAL_MAX));
    // just past the limit and at the top of the index range
    issue_request(vertex_request(ACT_LOAD,  16'd4096,  16'sh0000, 32'sh0000_0001));
    issue_request(vertex_request(ACT_ADD,   16'd4096,  16'sh1000, 32'sh0000_0001));
    issue_request(vertex_request(ACT_READ,  16'hffff,  16'sh0000, 32'sh0000_0000));
    issue_request(vertex_request(ACT_SPARE, 16'hffff,  16'sh0000, 32'sh0000_0000));

    // a count above the store size is clipped to it
    set_vertex_count(8191);
    issue_request(vertex_request(ACT_READ, 16'd4095, 16'sh0000, 32'sh0000_0000));
    issue_request(vertex_request(ACT_LOAD, 16'd4096, 16'sh0000, VAL_MAX));

    set_vertex_count(1);
    issue_request(vertex_request(ACT_READ, 16'd0, 16'sh0000, 32'sh0000_0000));
    issue_request(vertex_request(ACT_READ, 16'd1, 16'sh0000, 32'sh0000_0000));
    issue_request(vertex_request(ACT_ADD,  16'd0, -16'sh1000, 32'sh0001_0000));

    // Random phases over several counts; halfway through each, pause until
    // every result is back so the block also restarts from empty.
    foreach (phase_counts[p]) begin
      set_vertex_count(phase_counts[p]);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n == PHASE_LEN / 2)
          drain_requests();
        issue_request(random_request());
      end
    end

    drain_requests();
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
